// File: src/mbrw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrw_pkg: shared types and constants of the MCU block to raster writer
// Holds the register map, the configuration struct and the pixel word that
// travels from the position tracker to the write stage.
// ----------------------------------------------------------------------------
package mbrw_pkg;

  // framebuffer row pitch in pixels
  localparam int ROW_PITCH   = 256;
  // depth of the queue between tracker and write stage
  localparam int QUEUE_DEPTH = 2;

  // register map
  localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_MCU_WIDTH       = 3'd2;
  localparam logic [2:0] CFG_MCU_HEIGHT      = 3'd3;
  localparam logic [2:0] CFG_MCUS_PER_ROW    = 3'd4;
  localparam logic [2:0] CFG_MCUS_PER_COLUMN = 3'd5;
  localparam logic [2:0] CFG_FRAME_BASE      = 3'd6;

  typedef struct packed {
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic [4:0]  mcu_width;
    logic [4:0]  mcu_height;
    logic [5:0]  mcus_per_row;
    logic [5:0]  mcus_per_column;
    logic [15:0] frame_base;
  } cfg_t;

  // classified pixel word: image coordinates plus color
  typedef struct packed {
    logic       overflow;
    logic       in_image;
    logic [8:0] x;
    logic [9:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

endpackage
`default_nettype wire

// File: src/mbrw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrw_front: pixel position tracker
// Tracks pixel, block and MCU position, forms image coordinates, flags
// clipped and overflow pixels and advances the position per accepted word.
// ----------------------------------------------------------------------------
module mbrw_front import mbrw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       image_start_i,
  output pix_t            pix_o
);

  logic [2:0] col_q, col_d;
  logic [2:0] row_q, row_d;
  logic       bcol_q, bcol_d;
  logic       brow_q, brow_d;
  logic [4:0] mcol_q, mcol_d;
  logic [5:0] mrow_q, mrow_d;

  // positions as seen by this pixel (cleared on image start)
  logic [2:0] col_e, row_e;
  logic       bcol_e, brow_e;
  logic [4:0] mcol_e;
  logic [5:0] mrow_e;
  logic       across2, down2, ovf;
  logic [8:0] x;
  logic [9:0] y;

  always_comb begin
    col_e  = image_start_i ? 3'd0 : col_q;
    row_e  = image_start_i ? 3'd0 : row_q;
    bcol_e = image_start_i ? 1'b0 : bcol_q;
    brow_e = image_start_i ? 1'b0 : brow_q;
    mcol_e = image_start_i ? 5'd0 : mcol_q;
    mrow_e = image_start_i ? 6'd0 : mrow_q;
  end

  assign across2 = (cfg_i.mcu_width > 5'd8);
  assign down2   = (cfg_i.mcu_height > 5'd8);
  assign ovf     = (mrow_e >= cfg_i.mcus_per_column);

  // image coordinates
  always_comb begin
    x = (across2 ? {mcol_e, 4'd0} : {1'b0, mcol_e, 3'd0})
        + {5'd0, bcol_e, 3'd0} + {6'd0, col_e};
    y = (down2 ? {mrow_e, 4'd0} : {1'b0, mrow_e, 3'd0})
        + {6'd0, brow_e, 3'd0} + {7'd0, row_e};
  end

  always_comb begin
    pix_o.overflow = ovf;
    pix_o.in_image = ({1'b0, x} < {1'b0, cfg_i.image_width}) &&
                     (y < {1'b0, cfg_i.image_height});
    pix_o.x        = x;
    pix_o.y        = y;
    pix_o.red      = red_i;
    pix_o.green    = green_i;
    pix_o.blue     = blue_i;
  end

  // advance: pixel, row in block, block column, block row, MCU
  always_comb begin
    col_d  = col_e;
    row_d  = row_e;
    bcol_d = bcol_e;
    brow_d = brow_e;
    mcol_d = mcol_e;
    mrow_d = mrow_e;
    if (!ovf) begin
      if (col_e != 3'd7) begin
        col_d = col_e + 3'd1;
      end else begin
        col_d = 3'd0;
        if (row_e != 3'd7) begin
          row_d = row_e + 3'd1;
        end else begin
          row_d = 3'd0;
          if (across2 && !bcol_e) begin
            bcol_d = 1'b1;
          end else begin
            bcol_d = 1'b0;
            if (down2 && !brow_e) begin
              brow_d = 1'b1;
            end else begin
              brow_d = 1'b0;
              if (({1'b0, mcol_e} + 6'd1 >= cfg_i.mcus_per_row) || (mcol_e == 5'd31)) begin
                mcol_d = 5'd0;
                mrow_d = mrow_e + 6'd1;
              end else begin
                mcol_d = mcol_e + 5'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      bcol_q <= 1'b0;
      brow_q <= 1'b0;
      mcol_q <= '0;
      mrow_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
      mcol_q <= mcol_d;
      mrow_q <= mrow_d;
    end
  end

endmodule
`default_nettype wire

// File: src/mbrw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrw_queue: short word queue between tracker and write stage
// Small circular buffer of classified pixel words with a fill count.
// ----------------------------------------------------------------------------
module mbrw_queue import mbrw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire pix_t pix_i,
  output logic      full_o,
  input  wire logic pop_i,
  output pix_t      pix_o,
  output logic      empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pix_o   = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= pix_i;
    end
  end

endmodule
`default_nettype wire

// File: src/mbrw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrw_back: framebuffer write stage
// Forms the pixel address, packs RGB555 and holds the result word in an
// output register until it is popped.
// ----------------------------------------------------------------------------
module mbrw_back import mbrw_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire pix_t  pix_i,
  input  wire logic  avail_i,
  output logic       take_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output logic       write_enable_o,
  output logic [15:0] pixel_address_o,
  output logic [15:0] pixel_value_o,
  output logic       overflow_o
);

  logic        valid_q;
  logic        we_d, ovf_d;
  logic [15:0] addr_d, value_d;
  logic [15:0] row_off;

  // load a new word when the output is free or is being popped
  assign take_o  = avail_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;

  assign row_off = 16'(32'(pix_i.y) * ROW_PITCH);

  always_comb begin
    if (pix_i.overflow) begin
      we_d    = 1'b0;
      addr_d  = '0;
      value_d = '0;
      ovf_d   = 1'b1;
    end else begin
      we_d    = pix_i.in_image;
      addr_d  = cfg_i.frame_base + row_off + {7'd0, pix_i.x};
      value_d = {1'b1, pix_i.blue[7:3], pix_i.green[7:3], pix_i.red[7:3]};
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      write_enable_o  <= we_d;
      pixel_address_o <= addr_d;
      pixel_value_o   <= value_d;
      overflow_o      <= ovf_d;
    end
  end

endmodule
`default_nettype wire

// File: src/mcu_block_to_raster_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcu_block_to_raster_writer: places decoded JPEG pixels into an RGB555
// framebuffer
// Position tracker, short queue and write stage with an output register.
// ----------------------------------------------------------------------------
// Accepts one RGB888 pixel word per clock while full is low and returns
// one result word per pixel, in order: address frame_base + y * 256 + x
// (mod 2^16), the RGB555 value with bit 15 set, a write enable that is low
// for pixels clipped at the image edges, and an overflow flag for pixels
// past the last MCU row (those carry zero address and value and do not
// advance the position). A word that meets no stall passes the queue and
// then the output register before it can be popped; the two-entry queue
// between the position tracker and the write stage keeps one pixel per
// clock going while pop stays high.
// Configuration writes take effect at the next clock and belong to idle
// periods only.
module mcu_block_to_raster_writer import mbrw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic        image_start_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             write_enable_o,
  output logic [15:0]      pixel_address_o,
  output logic [15:0]      pixel_value_o,
  output logic             overflow_o
);

  cfg_t cfg_q;
  pix_t front_pix, queue_pix;
  logic accept, q_empty, q_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width     <= 9'd256;
      cfg_q.image_height    <= 9'd192;
      cfg_q.mcu_width       <= 5'd8;
      cfg_q.mcu_height      <= 5'd8;
      cfg_q.mcus_per_row    <= 6'd32;
      cfg_q.mcus_per_column <= 6'd24;
      cfg_q.frame_base      <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data_i[8:0];
        CFG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data_i[8:0];
        CFG_MCU_WIDTH:       cfg_q.mcu_width       <= cfg_data_i[4:0];
        CFG_MCU_HEIGHT:      cfg_q.mcu_height      <= cfg_data_i[4:0];
        CFG_MCUS_PER_ROW:    cfg_q.mcus_per_row    <= cfg_data_i[5:0];
        CFG_MCUS_PER_COLUMN: cfg_q.mcus_per_column <= cfg_data_i[5:0];
        CFG_FRAME_BASE:      cfg_q.frame_base      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  // position tracker
  mbrw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .image_start_i (image_start_i),
    .pix_o         (front_pix)
  );

  // decoupling queue
  mbrw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pix_i   (front_pix),
    .full_o  (full),
    .pop_i   (q_take),
    .pix_o   (queue_pix),
    .empty_o (q_empty)
  );

  // write stage
  mbrw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pix_i           (queue_pix),
    .avail_i         (!q_empty),
    .take_o          (q_take),
    .pop_i           (pop),
    .empty_o         (empty),
    .write_enable_o  (write_enable_o),
    .pixel_address_o (pixel_address_o),
    .pixel_value_o   (pixel_value_o),
    .overflow_o      (overflow_o)
  );

  // overflow words carry nothing to write
  a_ovf_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> (!write_enable_o && pixel_address_o == 16'd0 &&
                                pixel_value_o == 16'd0))
    else $error("overflow word carries write data");

  // every regular word has the RGB555 opaque bit
  a_opaque : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !overflow_o) |-> pixel_value_o[15])
    else $error("pixel word lost its top bit");

  // an accepted pixel reaches the result side through the queue and the output register
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> ##2 !empty)
    else $error("accepted pixel did not reach the output");

endmodule
`default_nettype wire

// File: tb/mbrw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrw_checker: result checker for the MCU block to raster writer
// Watches the configuration port and both queue sides, keeps its own copy of
// the registers and of the block and MCU position, predicts one raster word
// per pushed pixel and compares every popped word with the oldest prediction.
// ----------------------------------------------------------------------------
module mbrw_checker import mbrw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        image_start_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        write_enable_i,
  input  logic [15:0] pixel_address_i,
  input  logic [15:0] pixel_value_i,
  input  logic        overflow_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic        write_enable;
    logic [15:0] pixel_address;
    logic [15:0] pixel_value;
    logic        overflow;
  } raster_word_t;

  // register copy and raster position
  cfg_t         regs;
  logic [2:0]   col_in_blk;
  logic [2:0]   row_in_blk;
  logic         blk_col;
  logic         blk_row;
  logic [4:0]   mcu_col;
  logic [5:0]   mcu_row;
  raster_word_t pending_writes[$];
  int           mismatches;

  function automatic int check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // place one pixel: raster word out, position advanced
  task automatic place_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic start, output raster_word_t word);
    int across;
    int down;
    int x;
    int y;
    across = (regs.mcu_width > 5'd8) ? 2 : 1;
    down   = (regs.mcu_height > 5'd8) ? 2 : 1;
    word   = '0;
    if (start) begin
      col_in_blk = '0;
      row_in_blk = '0;
      blk_col    = 1'b0;
      blk_row    = 1'b0;
      mcu_col    = '0;
      mcu_row    = '0;
    end
    // past the last MCU row: flagged, zero payload, position frozen
    if (mcu_row >= regs.mcus_per_column) begin
      word.overflow = 1'b1;
      return;
    end
    x = int'(mcu_col) * across * 8 + int'(blk_col) * 8 + int'(col_in_blk);
    y = int'(mcu_row) * down * 8 + int'(blk_row) * 8 + int'(row_in_blk);
    word.write_enable  = (x < int'(regs.image_width)) && (y < int'(regs.image_height));
    word.pixel_address = 16'(int'(regs.frame_base) + y * ROW_PITCH + x);
    word.pixel_value   = {1'b1, b[7:3], g[7:3], r[7:3]};
    // advance: column, row, block column, block row, then MCU
    if (col_in_blk != 3'd7) begin
      col_in_blk++;
    end else begin
      col_in_blk = '0;
      if (row_in_blk != 3'd7) begin
        row_in_blk++;
      end else begin
        row_in_blk = '0;
        if (int'(blk_col) + 1 < across) begin
          blk_col = 1'b1;
        end else begin
          blk_col = 1'b0;
          if (int'(blk_row) + 1 < down) begin
            blk_row = 1'b1;
          end else begin
            blk_row = 1'b0;
            // row of MCUs ends at mcus_per_row or at column 31
            if (int'(mcu_col) + 1 >= int'(regs.mcus_per_row) || mcu_col == 5'd31) begin
              mcu_col = '0;
              mcu_row++;
            end else begin
              mcu_col++;
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    raster_word_t predicted;
    raster_word_t head;
    if (!rst_ni) begin
      regs = '{image_width: 9'd256, image_height: 9'd192, mcu_width: 5'd8,
               mcu_height: 5'd8, mcus_per_row: 6'd32, mcus_per_column: 6'd24,
               frame_base: 16'd0};
      col_in_blk = '0;
      row_in_blk = '0;
      blk_col    = 1'b0;
      blk_row    = 1'b0;
      mcu_col    = '0;
      mcu_row    = '0;
      pending_writes.delete();
      mismatches = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:     regs.image_width     = cfg_data_i[8:0];
          CFG_IMAGE_HEIGHT:    regs.image_height    = cfg_data_i[8:0];
          CFG_MCU_WIDTH:       regs.mcu_width       = cfg_data_i[4:0];
          CFG_MCU_HEIGHT:      regs.mcu_height      = cfg_data_i[4:0];
          CFG_MCUS_PER_ROW:    regs.mcus_per_row    = cfg_data_i[5:0];
          CFG_MCUS_PER_COLUMN: regs.mcus_per_column = cfg_data_i[5:0];
          CFG_FRAME_BASE:      regs.frame_base      = cfg_data_i;
          default: ;
        endcase
      end
      // accepted pixel word
      if (push_i && !full_i) begin
        place_pixel(red_i, green_i, blue_i, image_start_i, predicted);
        pending_writes.push_back(predicted);
      end
      // accepted result word
      if (pop_i && !empty_i) begin
        if (pending_writes.size() == 0) begin
          $error("result word with no pixel pending");
          mismatches++;
        end else begin
          head = pending_writes.pop_front();
          mismatches += check_field("write_enable", 16'(head.write_enable),
                                    16'(write_enable_i));
          mismatches += check_field("pixel_address", head.pixel_address, pixel_address_i);
          mismatches += check_field("pixel_value", head.pixel_value, pixel_value_i);
          mismatches += check_field("overflow", 16'(head.overflow), 16'(overflow_i));
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= pending_writes.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the MCU block to raster writer
// Drives pixel words in random bursts over many register settings, pops
// results on a stall pattern of its own and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mbrw_pkg::*;

  localparam int RANDOM_PIXELS = 320;
  localparam int STALL_LIMIT   = 2000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_data    = '0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  red         = '0;
  logic [7:0]  green       = '0;
  logic [7:0]  blue        = '0;
  logic        image_start = 1'b0;
  logic        empty;
  logic        pop         = 1'b0;
  logic        write_enable;
  logic [15:0] pixel_address;
  logic [15:0] pixel_value;
  logic        overflow;
  int          errors;
  int          pending;
  int          burst_left  = 0;
  int          idle_count  = 0;

  always #6 clk = ~clk;

  mcu_block_to_raster_writer uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .image_start_i   (image_start),
    .empty           (empty),
    .pop             (pop),
    .write_enable_o  (write_enable),
    .pixel_address_o (pixel_address),
    .pixel_value_o   (pixel_value),
    .overflow_o      (overflow)
  );

  mbrw_checker raster_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push_i          (push),
    .full_i          (full),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .image_start_i   (image_start),
    .empty_i         (empty),
    .pop_i           (pop),
    .write_enable_i  (write_enable),
    .pixel_address_i (pixel_address),
    .pixel_value_i   (pixel_value),
    .overflow_i      (overflow),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // one pixel word, sent in bursts with random gaps
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic start);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 3) begin
        gap        = 0;
        burst_left = $urandom_range(40, 80);
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
      end
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push        <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    image_start <= start;
    do @(posedge clk); while (full);
  endtask

  // stop sending until every predicted word has come out
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    for (int i = 0; i <= 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      case (3'(i))
        CFG_IMAGE_WIDTH:     cfg_data <= 16'(c.image_width);
        CFG_IMAGE_HEIGHT:    cfg_data <= 16'(c.image_height);
        CFG_MCU_WIDTH:       cfg_data <= 16'(c.mcu_width);
        CFG_MCU_HEIGHT:      cfg_data <= 16'(c.mcu_height);
        CFG_MCUS_PER_ROW:    cfg_data <= 16'(c.mcus_per_row);
        CFG_MCUS_PER_COLUMN: cfg_data <= 16'(c.mcus_per_column);
        default:             cfg_data <= c.frame_base;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly 8 or 16, now and then an odd size
  function automatic logic [4:0] random_mcu_size();
    case ($urandom_range(0, 5))
      0, 1:    return 5'd8;
      2, 3:    return 5'd16;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // small MCU grids keep frames short; zero and large counts now and then
  function automatic logic [5:0] random_mcu_count();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(0, 63));
      default: return 6'($urandom_range(1, 3));
    endcase
  endfunction

  // clip size around the frame extent, with extremes
  function automatic logic [8:0] random_clip(input int span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 9'($urandom_range(1, span + 8));
      5, 6:          return 9'd256;
      7:             return 9'($urandom_range(0, 511));
      default:       return 9'd1;
    endcase
  endfunction

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_count <= 0;
      end else if (idle_count == STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // receiver: stall pattern in runs, plus long hold-offs to fill the block
  initial begin
    int popped;
    int next_hold;
    int run_left;
    int mode;
    popped    = 0;
    next_hold = 120;
    run_left  = 0;
    mode      = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) popped++;
      if (popped == next_hold) begin
        pop <= 1'b0;
        next_hold += 350;
        repeat (64) @(posedge clk);
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(8, 48);
      end
      run_left--;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ~pop;
      endcase
    end
  end

  // stimulus and verdict
  initial begin
    cfg_t c;
    int   across;
    int   down;
    int   mpr_eff;
    int   pixels_per_frame;
    int   len;
    int   frames;
    int   pixels_sent;
    bit   paused;
    pixels_sent = 0;
    paused      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: color extremes, image start in mid stream
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hff, 1'b1);
    send_pixel(8'h08, 8'h07, 8'hf8, 1'b0);

    // no MCU rows at all: every pixel overflows; odd MCU sizes, zero per row
    wait_drained();
    write_config('{image_width: 9'd3, image_height: 9'd1, mcu_width: 5'd9,
                   mcu_height: 5'd0, mcus_per_row: 6'd0, mcus_per_column: 6'd0,
                   frame_base: 16'hffff});
    send_pixel(8'hff, 8'h00, 8'hff, 1'b1);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h40, 8'h20, 1'b1);

    // tight clip window with address wrap at the top of the buffer
    wait_drained();
    write_config('{image_width: 9'd4, image_height: 9'd1, mcu_width: 5'd31,
                   mcu_height: 5'd16, mcus_per_row: 6'd0, mcus_per_column: 6'd1,
                   frame_base: 16'hfffe});
    for (int k = 0; k < 10; k++) begin
      send_pixel(8'(k * 29), 8'(255 - k * 17), 8'(k[0] ? 8'hff : 8'h00), k == 0);
    end

    // wide MCU row: a per-row count above the 32-column cap, first MCUs
    wait_drained();
    write_config('{image_width: 9'd256, image_height: 9'd256, mcu_width: 5'd8,
                   mcu_height: 5'd8, mcus_per_row: 6'd63, mcus_per_column: 6'd1,
                   frame_base: 16'($urandom)});
    for (int k = 0; k < 256; k++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), k == 0);
    end

    // random settings, mostly whole frames with random pixels
    while (pixels_sent < RANDOM_PIXELS) begin
      c.mcu_width       = random_mcu_size();
      c.mcu_height      = random_mcu_size();
      c.mcus_per_row    = random_mcu_count();
      c.mcus_per_column = random_mcu_count();
      across  = (c.mcu_width > 5'd8) ? 2 : 1;
      down    = (c.mcu_height > 5'd8) ? 2 : 1;
      mpr_eff = (c.mcus_per_row == 6'd0) ? 1 :
                (c.mcus_per_row > 6'd32) ? 32 : int'(c.mcus_per_row);
      c.image_width  = random_clip(mpr_eff * across * 8);
      c.image_height = random_clip(int'(c.mcus_per_column) * down * 8);
      case ($urandom_range(0, 4))
        0:       c.frame_base = 16'h0000;
        1:       c.frame_base = 16'hffff;
        2:       c.frame_base = 16'($urandom_range(65000, 65535));
        default: c.frame_base = 16'($urandom);
      endcase
      pixels_per_frame = across * down * 64 * mpr_eff * int'(c.mcus_per_column);
      wait_drained();
      write_config(c);
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        len = (pixels_per_frame > 160) ? $urandom_range(64, 160) : pixels_per_frame;
        len += $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          // one pause in mid frame until the block has emptied
          if (!paused && pixels_sent >= 150) begin
            paused = 1'b1;
            wait_drained();
          end
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                     (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 150) == 0));
          pixels_sent++;
        end
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
